FILE: sv/adcep_pkg.sv
// adcep_pkg: shared types, constants and helpers for the adc entropy pool
// used by adcep_ctrl, adcep_datapath and adc_entropy_pool; no dependencies
`timescale 1ns / 1ps

package adcep_pkg;

    // reset value of the refeed register and of the refeed counter
    localparam logic [7:0] REFEED_RESET = 8'd100;

    // item codes on the cmd field
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_DONE
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_sample;  // latch mix byte, restart sweep, step refeed counter
        logic start_read;   // read pool at read pointer, advance pointer
        logic mix_rd;       // read one pool entry of the mixing sweep
        logic load_out;     // move the finished result into the output register
    } ctl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic sweep_last;   // sweep points at the last pool entry
        logic out_free;     // output register can take a result this cycle
    } ctl_stat_t;

    // rotate a byte right by 0 to 7 bits
    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] dbl;
        logic [15:0] sh;
        dbl = {v, v};
        sh  = dbl >> n;
        return sh[7:0];
    endfunction

endpackage

FILE: sv/adcep_ctrl.sv
// adcep_ctrl: sequencing state machine of the adc entropy pool
// depends on adcep_pkg for the state enum and the command/status structs
`timescale 1ns / 1ps

module adcep_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 cmd,
    input  adcep_pkg::ctl_stat_t stat,
    output adcep_pkg::ctl_cmd_t  ctl,
    output logic                 in_stall
);

    adcep_pkg::ctrl_state_t state_reg;
    adcep_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= adcep_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            adcep_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cmd == adcep_pkg::CMD_READ)
                    begin
                        ctl.start_read = 1'b1;
                        state_next     = adcep_pkg::ST_DONE;
                    end
                    else
                    begin
                        ctl.load_sample = 1'b1;
                        state_next      = adcep_pkg::ST_MIX;
                    end
                end
            end
            adcep_pkg::ST_MIX:
            begin
                ctl.mix_rd = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = adcep_pkg::ST_DONE;
                end
            end
            adcep_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = adcep_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adcep_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/adcep_datapath.sv
// adcep_datapath: pool memory, pointers, refeed counter and output register
// depends on adcep_pkg for the command/status structs and the rotate helper
`timescale 1ns / 1ps

module adcep_datapath
#(
    parameter int POOL_BYTES = 33
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  adcep_pkg::ctl_cmd_t  ctl,
    output adcep_pkg::ctl_stat_t stat,
    input  logic [7:0]           sample_high,
    input  logic [7:0]           sample_low,
    input  logic                 cfg_write_en,
    input  logic [7:0]           cfg_write_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [7:0]           random_out,
    output logic                 start_conversion
);

    localparam int IDX_W = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_BYTES - 1);
    localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(POOL_BYTES / 2);
    localparam logic [IDX_W:0]   WRAP_IDX = (IDX_W + 1)'(POOL_BYTES);

    // pool storage and per-entry valid bits (unwritten entries read as zero)
    logic [7:0]            pool_mem [POOL_BYTES];
    logic [POOL_BYTES-1:0] valid_reg;

    logic [7:0]       refeed_samples_reg;
    logic [7:0]       refeed_left_reg;
    logic [7:0]       refeed_left_next;
    logic [IDX_W-1:0] read_index_reg;
    logic [IDX_W-1:0] read_index_next;
    logic [IDX_W-1:0] sweep_reg;
    logic [IDX_W-1:0] sweep_next;
    logic [7:0]       mix_reg;
    logic             conv_reg;
    logic             conv_next;
    logic             is_read_reg;
    logic             wr_pend_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic             out_valid_reg;
    logic [7:0]       random_out_reg;
    logic             start_conv_reg;

    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic [7:0]       rd_eff;
    logic [IDX_W+2:0] wr_addr_ext;
    logic [2:0]       rot_amt;
    logic [7:0]       wr_data;
    logic [IDX_W:0]   idx_inc;
    logic [7:0]       left_dec;

    // memory port selection and read-modify-write data
    assign rd_en       = ctl.start_read | ctl.mix_rd;
    assign rd_addr     = ctl.start_read ? read_index_reg : sweep_reg;
    assign rd_eff      = rd_vld_reg ? rd_data_reg : 8'd0;
    assign wr_addr_ext = {3'b000, wr_addr_reg};
    assign rot_amt     = wr_addr_ext[2:0];
    assign wr_data     = rd_eff ^ adcep_pkg::rotr8(mix_reg, rot_amt);

    // pool memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            pool_mem[wr_addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= pool_mem[rd_addr];
        end
    end

    // valid bits follow the memory port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_pend_reg)
            begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    // pointer, sweep and refeed counter updates
    always_comb
    begin
        read_index_next  = read_index_reg;
        refeed_left_next = refeed_left_reg;
        sweep_next       = sweep_reg;
        conv_next        = conv_reg;
        idx_inc          = {1'b0, read_index_reg} + (IDX_W + 1)'(1);
        left_dec         = refeed_left_reg - 8'd1;

        if (ctl.load_sample)
        begin
            sweep_next       = '0;
            refeed_left_next = left_dec;
            conv_next        = (left_dec != 8'd0);
        end
        else if (ctl.mix_rd)
        begin
            if (sweep_reg != LAST_IDX)
            begin
                sweep_next = sweep_reg + IDX_W'(1);
            end
        end

        if (ctl.start_read)
        begin
            conv_next = 1'b0;
            if (idx_inc == WRAP_IDX)
            begin
                read_index_next  = '0;
                refeed_left_next = refeed_samples_reg;
                conv_next        = 1'b1;
            end
            else
            begin
                read_index_next = idx_inc[IDX_W-1:0];
            end
            if (read_index_next == HALF_IDX)
            begin
                refeed_left_next = refeed_samples_reg;
                conv_next        = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refeed_samples_reg <= adcep_pkg::REFEED_RESET;
            refeed_left_reg    <= adcep_pkg::REFEED_RESET;
            read_index_reg     <= '0;
            sweep_reg          <= '0;
            wr_pend_reg        <= 1'b0;
            conv_reg           <= 1'b0;
            is_read_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                refeed_samples_reg <= cfg_write_data;
            end
            refeed_left_reg <= refeed_left_next;
            read_index_reg  <= read_index_next;
            sweep_reg       <= sweep_next;
            wr_pend_reg     <= ctl.mix_rd;
            conv_reg        <= conv_next;
            if (ctl.start_read)
            begin
                is_read_reg <= 1'b1;
            end
            else if (ctl.load_sample)
            begin
                is_read_reg <= 1'b0;
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_sample)
        begin
            mix_reg <= sample_high ^ sample_low;
        end
        wr_addr_reg <= sweep_reg;
        if (ctl.load_out)
        begin
            random_out_reg <= is_read_reg ? rd_eff : 8'd0;
            start_conv_reg <= conv_reg;
        end
    end

    // status and output beat
    assign stat.sweep_last = (sweep_reg == LAST_IDX);
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign random_out       = random_out_reg;
    assign start_conversion = start_conv_reg;

endmodule

FILE: sv/adc_entropy_pool.sv
// adc_entropy_pool: top level, joins the controller and the datapath
// depends on adcep_pkg, adcep_ctrl and adcep_datapath
`timescale 1ns / 1ps

// Entropy pool mixed from ADC samples, one item at a time. A sample beat (cmd 0)
// folds sample_high ^ sample_low into every pool byte, entry i rotated right by
// i mod 8, walking the pool memory one entry per cycle. A read beat (cmd 1)
// is served by a registered memory read. A result that waits on out_stall holds the
// block in its final state; the next beat is taken once that result has moved
// into the output register. The pool reads as zeros after reset through
// per-entry valid bits, so there is no clearing pass. cfg_write_en /
// cfg_write_data set refeed_samples; the user must write them only while the
// block is idle, and the block itself does not enforce it.

module adc_entropy_pool
#(
    parameter int POOL_BYTES = 33
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] sample_high,
    input  logic [7:0] sample_low,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] random_out,
    output logic       start_conversion,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data
);

    adcep_pkg::ctl_cmd_t  ctl;
    adcep_pkg::ctl_stat_t stat;

    // sequencing
    adcep_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

    // pool and counters
    adcep_datapath
    #(
        .POOL_BYTES (POOL_BYTES)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .sample_high      (sample_high),
        .sample_low       (sample_low),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .random_out       (random_out),
        .start_conversion (start_conversion)
    );

    // an accepted beat makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again without going busy");

    // sweep reads and pointer reads never share the memory port
    a_one_reader: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.mix_rd && ctl.start_read))
        else $error("two reads on the pool port");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> stat.out_free)
        else $error("result overwrote a waiting beat");

    // every loaded result shows up as a valid output beat
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> out_valid)
        else $error("loaded result not presented");

endmodule
